FILE: src/npbm_pkg.sv
package npbm_pkg;

  // Default sizes
  localparam int DimBitsDef   = 16;
  localparam int MaxDigitsDef = 5;

  // Fixed result field widths
  localparam int HdrW  = 16;
  localparam int PixW  = 24;
  localparam int TypeW = 3;
  localparam int CntW  = 4;

  // Character codes
  localparam logic [7:0] ChP    = 8'h50;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] Ch0    = 8'h30;
  localparam logic [7:0] Ch1    = 8'h31;
  localparam logic [7:0] Ch6    = 8'h36;
  localparam logic [7:0] Ch7    = 8'h37;
  localparam logic [7:0] Ch9    = 8'h39;
  localparam logic [7:0] ChSp   = 8'h20;
  localparam logic [7:0] ChTab  = 8'h09;
  localparam logic [7:0] ChLf   = 8'h0a;
  localparam logic [7:0] ChCr   = 8'h0d;

  // Bitmap pixel levels
  localparam logic [PixW-1:0] BitOn  = 24'd255;
  localparam logic [PixW-1:0] BitOff = 24'd0;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_MAGIC   = 2'd0,
    ERR_NUMBER  = 2'd1,
    ERR_MAXVAL  = 2'd2,
    ERR_UNSUPP  = 2'd3
  } err_e;

  // Results caused by one byte: a single result, or a run of bitmap pixels
  typedef struct packed {
    logic             emit;
    logic [CntW-1:0]  cnt;
    kind_e            kind;
    logic [PixW-1:0]  value;
    err_e             err;
    logic             bitmap;
    logic             fin;
    logic [TypeW-1:0] img_type;
    logic [HdrW-1:0]  width;
    logic [HdrW-1:0]  height;
    logic [HdrW-1:0]  max_value;
  } bundle_t;

endpackage

FILE: src/npbm_parser.sv
module npbm_parser #(
  parameter int DIM_BITS   = npbm_pkg::DimBitsDef,
  parameter int MAX_DIGITS = npbm_pkg::MaxDigitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          in_byte_i,
  input  logic                start_of_file_i,
  output npbm_pkg::bundle_t   bundle_o
);

  localparam int AccW = $clog2(10 ** MAX_DIGITS);
  localparam int DcW  = $clog2(MAX_DIGITS + 1);
  localparam int PlW  = 2 * DIM_BITS;
  localparam int CmpW = (AccW > npbm_pkg::HdrW) ? AccW : npbm_pkg::HdrW;

  localparam logic [2:0] FmtP1 = 3'd1;
  localparam logic [2:0] FmtP3 = 3'd3;
  localparam logic [2:0] FmtP4 = 3'd4;
  localparam logic [2:0] FmtP5 = 3'd5;
  localparam logic [2:0] FmtP6 = 3'd6;

  typedef enum logic [3:0] {
    PH_MAGIC0, PH_MAGIC1, PH_WIDTH, PH_HEIGHT, PH_MAXVAL,
    PH_ASCII, PH_P4, PH_P5, PH_P6, PH_DONE, PH_ERROR
  } phase_e;

  phase_e              phase_q, phase_c, phase_d;
  logic [2:0]          fmt_q, fmt_c, fmt_d;
  logic [DIM_BITS-1:0] w_q, w_c, w_d;
  logic [DIM_BITS-1:0] h_q, h_c, h_d;
  logic [15:0]         mv_q, mv_c, mv_d;
  logic [AccW-1:0]     acc_q, acc_c, acc_d;
  logic [DcW-1:0]      dc_q, dc_c, dc_d;
  logic                cmt_q, cmt_c, cmt_d;
  logic [PlW-1:0]      left_q, left_c, left_d;
  logic [DIM_BITS-1:0] rc_q, rc_c, rc_d;
  logic [1:0]          ci_q, ci_c, ci_d;
  logic [15:0]         rgh_q, rgh_c, rgh_d;

  // Byte classes
  logic       is_ws, is_hash, is_dig;
  logic [3:0] dig;

  // Actions of this byte
  logic            do_commit, do_pix, do_hdr, do_fail, set_cmt;
  npbm_pkg::err_e  fcode;
  logic [npbm_pkg::PixW-1:0] pix_v;
  logic [AccW-1:0] cv;

  // Bitmap run
  logic [DIM_BITS-1:0] cols, rc_sum;
  logic [3:0]          run_n, run_m;

  npbm_pkg::bundle_t res;

  assign is_ws   = (in_byte_i == npbm_pkg::ChSp) ||
                   (in_byte_i inside {[npbm_pkg::ChTab:npbm_pkg::ChCr]});
  assign is_hash = (in_byte_i == npbm_pkg::ChHash);
  assign is_dig  = (in_byte_i inside {[npbm_pkg::Ch0:npbm_pkg::Ch9]});
  assign dig     = 4'(in_byte_i - npbm_pkg::Ch0);

  always_comb begin
    // start of file discards all earlier state
    if (start_of_file_i) begin
      phase_c = PH_MAGIC0;
      fmt_c   = '0;
      w_c     = '0;
      h_c     = '0;
      mv_c    = '0;
      acc_c   = '0;
      dc_c    = '0;
      cmt_c   = 1'b0;
      left_c  = '0;
      rc_c    = '0;
      ci_c    = '0;
      rgh_c   = '0;
    end else begin
      phase_c = phase_q;
      fmt_c   = fmt_q;
      w_c     = w_q;
      h_c     = h_q;
      mv_c    = mv_q;
      acc_c   = acc_q;
      dc_c    = dc_q;
      cmt_c   = cmt_q;
      left_c  = left_q;
      rc_c    = rc_q;
      ci_c    = ci_q;
      rgh_c   = rgh_q;
    end

    phase_d = phase_c;
    fmt_d   = fmt_c;
    w_d     = w_c;
    h_d     = h_c;
    mv_d    = mv_c;
    acc_d   = acc_c;
    dc_d    = dc_c;
    cmt_d   = cmt_c;
    left_d  = left_c;
    rc_d    = rc_c;
    ci_d    = ci_c;
    rgh_d   = rgh_c;

    do_commit = 1'b0;
    do_pix    = 1'b0;
    do_hdr    = 1'b0;
    do_fail   = 1'b0;
    set_cmt   = 1'b0;
    fcode     = npbm_pkg::ERR_MAGIC;
    pix_v     = '0;
    cv        = acc_c;

    res        = '0;
    res.kind   = npbm_pkg::KIND_PIXEL;
    res.err    = npbm_pkg::ERR_MAGIC;
    res.cnt    = 4'd1;

    cols   = w_c - rc_c;
    run_n  = (cols > DIM_BITS'(8)) ? 4'd8 : cols[3:0];
    run_m  = (PlW'(run_n) > left_c) ? left_c[3:0] : run_n;
    rc_sum = rc_c + DIM_BITS'(run_n);

    // per-phase byte handling
    case (phase_c)
      PH_MAGIC0: begin
        if (in_byte_i == npbm_pkg::ChP) begin
          phase_d = PH_MAGIC1;
        end else begin
          do_fail = 1'b1;
          fcode   = npbm_pkg::ERR_MAGIC;
        end
      end
      PH_MAGIC1: begin
        if (in_byte_i inside {[npbm_pkg::Ch1:npbm_pkg::Ch6]}) begin
          fmt_d   = dig[2:0];
          phase_d = PH_WIDTH;
        end else if (in_byte_i == npbm_pkg::Ch7) begin
          do_fail = 1'b1;
          fcode   = npbm_pkg::ERR_UNSUPP;
        end else begin
          do_fail = 1'b1;
          fcode   = npbm_pkg::ERR_MAGIC;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCII: begin
        if (cmt_c) begin
          if (in_byte_i == npbm_pkg::ChLf || in_byte_i == npbm_pkg::ChCr) begin
            cmt_d = 1'b0;
          end
        end else if (is_dig) begin
          if (phase_c == PH_ASCII && fmt_c == FmtP1) begin
            if (dig > 4'd1) begin
              do_fail = 1'b1;
              fcode   = npbm_pkg::ERR_MAXVAL;
            end else begin
              do_pix = 1'b1;
              pix_v  = npbm_pkg::PixW'(dig);
            end
          end else if (dc_c >= DcW'(MAX_DIGITS)) begin
            do_fail = 1'b1;
            fcode   = npbm_pkg::ERR_NUMBER;
          end else begin
            acc_d = AccW'((acc_c << 3) + (acc_c << 1) + AccW'(dig));
            dc_d  = dc_c + 1'b1;
          end
        end else if (is_ws || is_hash) begin
          if (dc_c != '0) begin
            acc_d     = '0;
            dc_d      = '0;
            do_commit = 1'b1;
          end
          set_cmt = is_hash;
        end else begin
          do_fail = 1'b1;
          fcode   = npbm_pkg::ERR_NUMBER;
        end
      end
      PH_P4: begin
        // up to eight pixels, capped by the row end and the image end
        res.emit   = 1'b1;
        res.cnt    = run_m;
        res.bitmap = 1'b1;
        res.value  = npbm_pkg::PixW'(in_byte_i);
        res.fin    = (PlW'(run_m) == left_c);
        left_d     = left_c - PlW'(run_m);
        if (PlW'(run_m) == left_c) begin
          phase_d = PH_DONE;
        end
        rc_d = (rc_sum >= w_c) ? '0 : rc_sum;
      end
      PH_P5: begin
        do_pix = 1'b1;
        pix_v  = npbm_pkg::PixW'(in_byte_i);
      end
      PH_P6: begin
        if (ci_c == 2'd0) begin
          rgh_d = {8'h00, in_byte_i};
          ci_d  = 2'd1;
        end else if (ci_c == 2'd1) begin
          rgh_d = {in_byte_i, rgh_c[7:0]};
          ci_d  = 2'd2;
        end else begin
          ci_d   = 2'd0;
          do_pix = 1'b1;
          pix_v  = {in_byte_i, rgh_c};
        end
      end
      default: ;
    endcase

    // finished number: header field or ASCII sample
    if (do_commit) begin
      case (phase_c)
        PH_WIDTH: begin
          if ((cv >> DIM_BITS) != '0) begin
            do_fail = 1'b1;
            fcode   = npbm_pkg::ERR_NUMBER;
          end else begin
            w_d     = DIM_BITS'(cv);
            phase_d = PH_HEIGHT;
          end
        end
        PH_HEIGHT: begin
          if ((cv >> DIM_BITS) != '0) begin
            do_fail = 1'b1;
            fcode   = npbm_pkg::ERR_NUMBER;
          end else begin
            h_d = DIM_BITS'(cv);
            if (fmt_c == FmtP1 || fmt_c == FmtP4) begin
              mv_d   = 16'd1;
              do_hdr = 1'b1;
            end else begin
              phase_d = PH_MAXVAL;
            end
          end
        end
        PH_MAXVAL: begin
          if ((cv >> 16) != '0) begin
            do_fail = 1'b1;
            fcode   = npbm_pkg::ERR_NUMBER;
          end else begin
            mv_d   = 16'(cv);
            do_hdr = 1'b1;
          end
        end
        default: begin
          if (CmpW'(cv) > CmpW'(mv_c)) begin
            do_fail = 1'b1;
            fcode   = npbm_pkg::ERR_MAXVAL;
          end else if (fmt_c != FmtP3) begin
            do_pix = 1'b1;
            pix_v  = npbm_pkg::PixW'(cv);
          end else if (ci_c == 2'd0) begin
            rgh_d = {8'h00, cv[7:0]};
            ci_d  = 2'd1;
          end else if (ci_c == 2'd1) begin
            rgh_d = {cv[7:0], rgh_c[7:0]};
            ci_d  = 2'd2;
          end else begin
            ci_d   = 2'd0;
            do_pix = 1'b1;
            pix_v  = {cv[7:0], rgh_c};
          end
        end
      endcase
    end

    // end of header
    if (do_hdr) begin
      if (fmt_c >= FmtP4 && !is_ws) begin
        do_fail = 1'b1;
        fcode   = npbm_pkg::ERR_NUMBER;
      end else begin
        left_d   = PlW'(w_d) * PlW'(h_d);
        rc_d     = '0;
        ci_d     = '0;
        rgh_d    = '0;
        res.emit = 1'b1;
        res.kind = npbm_pkg::KIND_HEADER;
        if (w_d == '0 || h_d == '0) begin
          phase_d = PH_DONE;
        end else if (fmt_c == FmtP4) begin
          phase_d = PH_P4;
        end else if (fmt_c == FmtP5) begin
          phase_d = PH_P5;
        end else if (fmt_c == FmtP6) begin
          phase_d = PH_P6;
        end else begin
          phase_d = PH_ASCII;
        end
      end
    end

    // single pixel
    if (do_pix) begin
      left_d    = left_c - 1'b1;
      res.emit  = 1'b1;
      res.value = pix_v;
      res.fin   = (left_c == PlW'(1));
      if (left_c == PlW'(1)) begin
        phase_d = PH_DONE;
      end
    end

    // error ends the file
    if (do_fail) begin
      phase_d   = PH_ERROR;
      res       = '0;
      res.emit  = 1'b1;
      res.cnt   = 4'd1;
      res.kind  = npbm_pkg::KIND_ERROR;
      res.err   = fcode;
    end

    if (set_cmt && (phase_d inside {[PH_WIDTH:PH_ASCII]})) begin
      cmt_d = 1'b1;
    end

    // header state as it stands after this byte
    res.img_type  = fmt_d;
    res.width     = npbm_pkg::HdrW'(w_d);
    res.height    = npbm_pkg::HdrW'(h_d);
    res.max_value = mv_d;
  end

  assign bundle_o = res;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_MAGIC0;
      fmt_q   <= '0;
      w_q     <= '0;
      h_q     <= '0;
      mv_q    <= '0;
      acc_q   <= '0;
      dc_q    <= '0;
      cmt_q   <= 1'b0;
      left_q  <= '0;
      rc_q    <= '0;
      ci_q    <= '0;
      rgh_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      fmt_q   <= fmt_d;
      w_q     <= w_d;
      h_q     <= h_d;
      mv_q    <= mv_d;
      acc_q   <= acc_d;
      dc_q    <= dc_d;
      cmt_q   <= cmt_d;
      left_q  <= left_d;
      rc_q    <= rc_d;
      ci_q    <= ci_d;
      rgh_q   <= rgh_d;
    end
  end

endmodule

FILE: src/npbm_out_reg.sv
module npbm_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  npbm_pkg::bundle_t bundle_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        kind_o,
  output logic [23:0]       pixel_value_o,
  output logic [2:0]        image_type_o,
  output logic [15:0]       width_o,
  output logic [15:0]       height_o,
  output logic [15:0]       max_value_o,
  output logic [1:0]        error_code_o,
  output logic              last_pixel_o,
  output logic              last_o
);

  npbm_pkg::bundle_t bundle_q;
  logic              valid_q;
  logic [2:0]        rem_q;
  logic [2:0]        pos_q;
  logic              take;

  assign take   = valid_q && !out_stall_i;
  assign free_o = !valid_q || (take && rem_q == 3'd0);

  // result register, walks through a bitmap run one pixel per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rem_q   <= '0;
      pos_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      rem_q   <= 3'(bundle_i.cnt - 1'b1);
      pos_q   <= '0;
    end else if (take) begin
      if (rem_q == 3'd0) begin
        valid_q <= 1'b0;
      end else begin
        rem_q <= rem_q - 1'b1;
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign kind_o        = bundle_q.kind;
  assign pixel_value_o = !bundle_q.bitmap ? bundle_q.value :
                         (bundle_q.value[3'd7 - pos_q] ? npbm_pkg::BitOn : npbm_pkg::BitOff);
  assign image_type_o  = bundle_q.img_type;
  assign width_o       = bundle_q.width;
  assign height_o      = bundle_q.height;
  assign max_value_o   = bundle_q.max_value;
  assign error_code_o  = bundle_q.err;
  assign last_o        = (rem_q == 3'd0);
  assign last_pixel_o  = bundle_q.fin && (rem_q == 3'd0);

endmodule

FILE: src/netpbm_stream_decoder_top.sv
// NetPBM (P1..P6) byte stream decoder. One file byte is taken per request;
// start_of_file_i high restarts parsing on that byte. Results (header, pixel
// or error) leave one per request through a single output register, valid in
// the cycle after the byte that causes them is taken. While that register is
// empty or being emptied, a byte that gives no result or one result is
// accepted every cycle, back to back. A result held in the register by
// out_stall_i stalls the input, whether or not the next byte gives a result.
// A P4 byte that expands to m pixels (m up to 8) is handed out by the register
// one pixel per cycle while out_stall_i is low, and the input stays stalled
// until the last of those pixels is taken. Header width and height take
// DIM_BITS bits, and numbers take at most MAX_DIGITS decimal digits.
module netpbm_stream_decoder_top #(
  parameter int DIM_BITS   = npbm_pkg::DimBitsDef,
  parameter int MAX_DIGITS = npbm_pkg::MaxDigitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [23:0] pixel_value_o,
  output logic [2:0]  image_type_o,
  output logic [15:0] width_o,
  output logic [15:0] height_o,
  output logic [15:0] max_value_o,
  output logic [1:0]  error_code_o,
  output logic        last_pixel_o,
  output logic        last_o
);

  npbm_pkg::bundle_t bundle;
  logic              accept;
  logic              free;

  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  npbm_parser #(
    .DIM_BITS   (DIM_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .start_of_file_i (start_of_file_i),
    .bundle_o        (bundle)
  );

  npbm_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept && bundle.emit),
    .bundle_i      (bundle),
    .free_o        (free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .pixel_value_o (pixel_value_o),
    .image_type_o  (image_type_o),
    .width_o       (width_o),
    .height_o      (height_o),
    .max_value_o   (max_value_o),
    .error_code_o  (error_code_o),
    .last_pixel_o  (last_pixel_o),
    .last_o        (last_o)
  );

endmodule

FILE: verif/netpbm_stream_decoder_top_test.sv
`timescale 1ns / 1ps

module netpbm_stream_decoder_top_test;
  import npbm_pkg::*;

  localparam int unsigned DimMax    = (1 << DimBitsDef) - 1;
  localparam int unsigned MaxvalMax = 16'hFFFF;
  localparam int unsigned ByteMask  = 8'hFF;
  localparam logic [7:0]  ChVt      = 8'h0b;
  localparam logic [7:0]  ChFf      = 8'h0c;
  localparam int unsigned RandomBytes = 330;

  // Decoder progress, in the same order as the block walks through a file
  typedef enum logic [3:0] {
    ST_MAGIC0, ST_MAGIC1, ST_WIDTH, ST_HEIGHT, ST_MAXVAL, ST_ASCII,
    ST_P4, ST_P5, ST_P6, ST_DONE, ST_ERROR
  } parse_state_e;

  // Ways a random file is spoilt
  typedef enum int {
    FLAW_NONE, FLAW_BYTE, FLAW_CUT, FLAW_LONG, FLAW_BIG, FLAW_RANGE, FLAW_MAGIC
  } flaw_e;

  typedef struct {
    kind_e       kind;
    logic [23:0] value;
    logic [2:0]  img_type;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] max_value;
    err_e        err;
    logic        last_pixel;
    logic        last;
  } decoded_t;

  typedef struct {
    logic [7:0]  data;
    logic        sof;
    int unsigned gap;
    bit          drain;
  } byte_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_byte_i = 8'd0;
  logic        start_of_file_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [23:0] pixel_value_o;
  logic [2:0]  image_type_o;
  logic [15:0] width_o;
  logic [15:0] height_o;
  logic [15:0] max_value_o;
  logic [1:0]  error_code_o;
  logic        last_pixel_o;
  logic        last_o;

  netpbm_stream_decoder_top #(
    .DIM_BITS  (DimBitsDef),
    .MAX_DIGITS(MaxDigitsDef)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_byte_i      (in_byte_i),
    .start_of_file_i(start_of_file_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .pixel_value_o  (pixel_value_o),
    .image_type_o   (image_type_o),
    .width_o        (width_o),
    .height_o       (height_o),
    .max_value_o    (max_value_o),
    .error_code_o   (error_code_o),
    .last_pixel_o   (last_pixel_o),
    .last_o         (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow decoder state
  parse_state_e    pr_state;
  logic [2:0]      pr_type;
  int unsigned     pr_width, pr_height, pr_maxval;
  int unsigned     pr_accum, pr_digits;
  bit              pr_comment;
  longint unsigned pr_left;
  int unsigned     pr_col, pr_comp, pr_rg;
  int unsigned     step_count;

  decoded_t  results_due[$];
  byte_req_t file_stream[$];
  logic [7:0] image_bytes[$];

  int unsigned bytes_total, bytes_taken, results_taken, mismatches;
  int unsigned files_sent, headers_seen, pixels_seen, errors_seen;

  function automatic void clear_decoder();
    pr_state   = ST_MAGIC0;
    pr_type    = 3'd0;
    pr_width   = 0;
    pr_height  = 0;
    pr_maxval  = 0;
    pr_accum   = 0;
    pr_digits  = 0;
    pr_comment = 1'b0;
    pr_left    = 0;
    pr_col     = 0;
    pr_comp    = 0;
    pr_rg      = 0;
  endfunction

  function automatic bit is_space(logic [7:0] b);
    return b == ChSp || b == ChTab || b == ChLf || b == ChVt || b == ChFf || b == ChCr;
  endfunction

  // Every result carries the header as parsed so far
  function automatic void emit(kind_e k, logic [23:0] v, err_e e, logic lp);
    decoded_t r;
    r.kind       = k;
    r.value      = v;
    r.img_type   = pr_type;
    r.width      = pr_width[15:0];
    r.height     = pr_height[15:0];
    r.max_value  = pr_maxval[15:0];
    r.err        = e;
    r.last_pixel = lp;
    r.last       = 1'b0;
    results_due.push_back(r);
    step_count++;
  endfunction

  function automatic void raise_error(err_e e);
    pr_state = ST_ERROR;
    emit(KIND_ERROR, 24'd0, e, 1'b0);
  endfunction

  // Non-error results carry error code zero
  function automatic void emit_pixel(logic [23:0] v);
    if (pr_left > 0) pr_left--;
    if (pr_left == 0) begin
      pr_state = ST_DONE;
      emit(KIND_PIXEL, v, ERR_MAGIC, 1'b1);
    end else begin
      emit(KIND_PIXEL, v, ERR_MAGIC, 1'b0);
    end
  endfunction

  function automatic void end_header(bit ws);
    if (pr_type >= 4 && !ws) begin
      raise_error(ERR_NUMBER);
      return;
    end
    pr_left = longint'(pr_width) * longint'(pr_height);
    pr_col  = 0;
    pr_comp = 0;
    pr_rg   = 0;
    emit(KIND_HEADER, 24'd0, ERR_MAGIC, 1'b0);
    if (pr_left == 0) pr_state = ST_DONE;
    else if (pr_type == 4) pr_state = ST_P4;
    else if (pr_type == 5) pr_state = ST_P5;
    else if (pr_type == 6) pr_state = ST_P6;
    else pr_state = ST_ASCII;
  endfunction

  // A decimal number closed by a separator
  function automatic void take_number(int unsigned v, bit ws);
    int unsigned pix;
    case (pr_state)
      ST_WIDTH: begin
        if (v > DimMax) raise_error(ERR_NUMBER);
        else begin
          pr_width = v;
          pr_state = ST_HEIGHT;
        end
      end
      ST_HEIGHT: begin
        if (v > DimMax) raise_error(ERR_NUMBER);
        else begin
          pr_height = v;
          if (pr_type == 1 || pr_type == 4) begin
            pr_maxval = 1;
            end_header(ws);
          end else begin
            pr_state = ST_MAXVAL;
          end
        end
      end
      ST_MAXVAL: begin
        if (v > MaxvalMax) raise_error(ERR_NUMBER);
        else begin
          pr_maxval = v;
          end_header(ws);
        end
      end
      default: begin
        if (v > pr_maxval) raise_error(ERR_MAXVAL);
        else if (pr_type != 3) emit_pixel(v[23:0]);
        else if (pr_comp == 0) begin
          pr_rg   = v & ByteMask;
          pr_comp = 1;
        end else if (pr_comp == 1) begin
          pr_rg   = pr_rg | ((v & ByteMask) << 8);
          pr_comp = 2;
        end else begin
          pr_comp = 0;
          pix = pr_rg | ((v & ByteMask) << 16);
          emit_pixel(pix[23:0]);
        end
      end
    endcase
  endfunction

  // Header text and ASCII raster
  function automatic void decode_text(logic [7:0] b);
    int unsigned v;
    bit ws;
    ws = is_space(b);
    if (pr_comment) begin
      if (b == ChLf || b == ChCr) pr_comment = 1'b0;
    end else if (b >= Ch0 && b <= Ch9) begin
      if (pr_state == ST_ASCII && pr_type == 1) begin
        if (b > Ch1) raise_error(ERR_MAXVAL);
        else emit_pixel(24'(b - Ch0));
      end else if (pr_digits >= MaxDigitsDef) begin
        raise_error(ERR_NUMBER);
      end else begin
        pr_accum = pr_accum * 10 + 32'(b - Ch0);
        pr_digits++;
      end
    end else if (ws || b == ChHash) begin
      if (pr_digits > 0) begin
        v = pr_accum;
        pr_accum  = 0;
        pr_digits = 0;
        take_number(v, ws);
      end
      if (b == ChHash && pr_state >= ST_WIDTH && pr_state <= ST_ASCII) pr_comment = 1'b1;
    end else begin
      raise_error(ERR_NUMBER);
    end
  endfunction

  // P4: MSB first, padding bits at the end of a row dropped
  function automatic void decode_bitmap(logic [7:0] b);
    int unsigned n;
    n = pr_width - pr_col;
    if (n > 8) n = 8;
    for (int unsigned i = 0; i < n && pr_state == ST_P4; i++)
      emit_pixel(b[7-i] ? BitOn : BitOff);
    pr_col += n;
    if (pr_col >= pr_width) pr_col = 0;
  endfunction

  // Expected results for one accepted byte
  function automatic void decode_byte(logic [7:0] b, logic sof);
    decoded_t r;
    int unsigned pix;
    step_count = 0;
    if (sof) clear_decoder();
    case (pr_state)
      ST_MAGIC0: begin
        if (b == ChP) pr_state = ST_MAGIC1;
        else raise_error(ERR_MAGIC);
      end
      ST_MAGIC1: begin
        if (b >= Ch1 && b <= Ch6) begin
          pr_type  = 3'(b - Ch0);
          pr_state = ST_WIDTH;
        end else if (b == Ch7) begin
          raise_error(ERR_UNSUPP);
        end else begin
          raise_error(ERR_MAGIC);
        end
      end
      ST_WIDTH, ST_HEIGHT, ST_MAXVAL, ST_ASCII: decode_text(b);
      ST_P4: decode_bitmap(b);
      ST_P5: emit_pixel({16'd0, b});
      ST_P6: begin
        if (pr_comp == 0) begin
          pr_rg   = b;
          pr_comp = 1;
        end else if (pr_comp == 1) begin
          pr_rg   = pr_rg | (32'(b) << 8);
          pr_comp = 2;
        end else begin
          pr_comp = 0;
          pix = pr_rg | (32'(b) << 16);
          emit_pixel(pix[23:0]);
        end
      end
      default: ;
    endcase
    if (step_count > 0) begin
      r = results_due.pop_back();
      r.last = 1'b1;
      results_due.push_back(r);
    end
  endfunction

  // File building helpers
  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) image_bytes.push_back(s[i]);
  endfunction

  function automatic void put_space();
    logic [7:0] codes [6];
    codes = '{ChSp, ChTab, ChLf, ChCr, ChVt, ChFf};
    image_bytes.push_back(codes[$urandom_range(0, 5)]);
  endfunction

  function automatic void put_comment();
    logic [7:0] b;
    image_bytes.push_back(ChHash);
    repeat ($urandom_range(0, 4)) begin
      do b = 8'($urandom); while (b == ChLf || b == ChCr);
      image_bytes.push_back(b);
    end
    image_bytes.push_back($urandom_range(0, 1) ? ChLf : ChCr);
  endfunction

  function automatic void put_sep();
    repeat ($urandom_range(1, 2)) begin
      if ($urandom_range(0, 5) == 0) put_comment();
      else put_space();
    end
  endfunction

  // Decimal, sometimes zero padded; too_long forces one digit over the limit
  function automatic void put_number(int unsigned v, bit too_long);
    string s;
    s = $sformatf("%0d", v);
    if (too_long) begin
      while (s.len() <= MaxDigitsDef) s = {"0", s};
    end else begin
      while (s.len() < MaxDigitsDef && $urandom_range(0, 3) == 0) s = {"0", s};
    end
    put_text(s);
  endfunction

  // One random file, well formed or spoilt; counted excludes trailing junk
  task automatic build_file(output int unsigned counted);
    int unsigned ftype, w, h, mv, v, npix, nsamp, bad_at, target, nnum, idx;
    int unsigned hdr [3];
    flaw_e flaw;
    bit ascii;
    logic [7:0] b;
    image_bytes.delete();
    case ($urandom_range(0, 19))
      0, 1:    flaw = FLAW_BYTE;
      2:       flaw = FLAW_CUT;
      3:       flaw = FLAW_LONG;
      4:       flaw = FLAW_BIG;
      5, 6:    flaw = FLAW_RANGE;
      7:       flaw = FLAW_MAGIC;
      default: flaw = FLAW_NONE;
    endcase
    ftype = $urandom_range(1, 6);
    ascii = ftype <= 3;
    case ($urandom_range(0, 11))
      0: begin
        w = $urandom_range(0, 3);
        h = 0;
      end
      1: begin
        if ($urandom_range(0, 1)) begin
          w = DimMax;
          h = 0;
        end else begin
          w = 0;
          h = DimMax;
        end
      end
      2: begin
        w = (ftype == 4) ? $urandom_range(9, 20) : $urandom_range(5, 8);
        h = $urandom_range(1, 2);
      end
      default: begin
        w = $urandom_range(1, 4);
        h = $urandom_range(1, 3);
      end
    endcase
    case ($urandom_range(0, 4))
      0:       mv = $urandom_range(0, 1);
      1:       mv = MaxvalMax;
      2:       mv = ByteMask;
      default: mv = $urandom_range(1, 300);
    endcase
    if (flaw == FLAW_RANGE && mv == MaxvalMax) mv = MaxvalMax - 1;
    npix   = w * h;
    nsamp  = (ftype == 3 || ftype == 6) ? 3 * npix : npix;
    bad_at = (nsamp > 0) ? $urandom_range(0, nsamp - 1) : 0;
    nnum   = (ftype == 1 || ftype == 4) ? 2 : 3;
    target = $urandom_range(0, nnum - 1);

    // Magic
    if (flaw == FLAW_MAGIC) begin
      if ($urandom_range(0, 1)) begin
        do b = 8'($urandom); while (b == ChP);
        image_bytes.push_back(b);
      end else begin
        image_bytes.push_back(ChP);
        do b = 8'($urandom); while (b >= Ch1 && b <= Ch6);
        image_bytes.push_back(b);
      end
    end else begin
      image_bytes.push_back(ChP);
      image_bytes.push_back(Ch0 + 8'(ftype));
    end
    // a digit may follow the magic directly
    if ($urandom_range(0, 3) != 0) put_sep();

    // Header numbers
    hdr = '{w, h, mv};
    for (int unsigned i = 0; i < nnum; i++) begin
      v = hdr[i];
      if (flaw == FLAW_BIG && i == target) v = $urandom_range(DimMax + 1, 99999);
      put_number(v, flaw == FLAW_LONG && i == target);
      if (i < nnum - 1) put_sep();
      else if (ascii) put_sep();
      else if (flaw == FLAW_RANGE) image_bytes.push_back(ChHash);
      else put_space();
    end

    // Raster
    case (ftype)
      1: begin
        for (int unsigned i = 0; i < npix; i++) begin
          if (flaw == FLAW_RANGE && i == bad_at)
            image_bytes.push_back(Ch0 + 8'($urandom_range(2, 9)));
          else
            image_bytes.push_back(Ch0 + 8'($urandom_range(0, 1)));
          if ($urandom_range(0, 2) == 0) put_sep();
        end
      end
      2, 3: begin
        for (int unsigned i = 0; i < nsamp; i++) begin
          if (flaw == FLAW_RANGE && i == bad_at) v = mv + 1 + $urandom_range(0, 99);
          else v = $urandom_range(0, mv);
          put_number(v, 1'b0);
          put_sep();
        end
      end
      4: repeat (((w + 7) / 8) * h) image_bytes.push_back(8'($urandom));
      default: repeat (nsamp) image_bytes.push_back(8'($urandom));
    endcase

    if (flaw == FLAW_BYTE) begin
      idx = $urandom_range(0, image_bytes.size() - 1);
      image_bytes[idx] = 8'($urandom);
    end else if (flaw == FLAW_CUT && image_bytes.size() > 1) begin
      idx = $urandom_range(1, image_bytes.size() - 1);
      while (image_bytes.size() > idx) void'(image_bytes.pop_back());
    end
    counted = image_bytes.size();
    // bytes after the end are ignored
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) image_bytes.push_back(8'($urandom));
  endtask

  // Queue a built file as requests; some files go without sender gaps
  function automatic void add_file(bit drain);
    byte_req_t req;
    bit calm;
    calm = $urandom_range(0, 3) == 0;
    foreach (image_bytes[i]) begin
      req.data  = image_bytes[i];
      req.sof   = (i == 0);
      req.gap   = calm ? 0 : $urandom_range(0, 4);
      req.drain = drain && (i == 0);
      file_stream.push_back(req);
    end
    bytes_total += image_bytes.size();
    files_sent++;
    image_bytes.delete();
  endfunction

  // Driver: a gap before each request, optionally waiting for all results first
  int unsigned gap_left;
  bit          holding;
  byte_req_t   next_req;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      in_byte_i       <= 8'd0;
      start_of_file_i <= 1'b0;
      gap_left = 0;
    end else begin
      holding = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        decode_byte(in_byte_i, start_of_file_i);
        bytes_taken++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (file_stream.size() != 0 &&
                     !(file_stream[0].drain && results_due.size() != 0)) begin
          next_req = file_stream.pop_front();
          in_byte_i       <= next_req.data;
          start_of_file_i <= next_req.sof;
          in_valid_i      <= 1'b1;
          gap_left = (file_stream.size() != 0) ? file_stream[0].gap : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, longint unsigned exp, longint unsigned act);
    if (exp != act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      mismatches++;
    end
  endfunction

  // Monitor: compare each result with the oldest expectation
  int unsigned stall_left;
  bit          out_calm;
  decoded_t    got_due;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
      out_calm   = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_taken++;
        if (results_due.size() == 0) begin
          $error("result with nothing expected: kind %0d value %0d", kind_o, pixel_value_o);
          mismatches++;
        end else begin
          got_due = results_due.pop_front();
          check_field("kind", got_due.kind, kind_o);
          check_field("pixel_value", got_due.value, pixel_value_o);
          check_field("image_type", got_due.img_type, image_type_o);
          check_field("width", got_due.width, width_o);
          check_field("height", got_due.height, height_o);
          check_field("max_value", got_due.max_value, max_value_o);
          check_field("error_code", got_due.err, error_code_o);
          check_field("last_pixel", got_due.last_pixel, last_pixel_o);
          check_field("last", got_due.last, last_o);
          case (got_due.kind)
            KIND_HEADER: headers_seen++;
            KIND_PIXEL:  pixels_seen++;
            default:     errors_seen++;
          endcase
        end
        if (results_taken % 32 == 0) out_calm = $urandom_range(0, 2) == 0;
        stall_left = out_calm ? 0 : $urandom_range(0, 4);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus and end of run
  int unsigned random_bytes, file_bytes;

  initial begin
    clear_decoder();

    // Directed: bad magic then an ignored all-ones byte
    put_text("X");
    image_bytes.push_back(8'hFF);
    add_file(1'b0);
    // unsupported P7
    put_text("P7");
    add_file(1'b0);
    // P1 2x1, pixels without separators
    put_text("P12 1 10");
    add_file(1'b0);
    // P4 1x1, padding bits dropped, trailing byte ignored
    put_text("P41 1\n");
    image_bytes.push_back(8'h80);
    image_bytes.push_back(8'h00);
    add_file(1'b0);

    // Random files; every sixth one waits for the decoder to drain
    random_bytes = 0;
    while (random_bytes < RandomBytes) begin
      build_file(file_bytes);
      add_file((files_sent % 6) == 4);
      random_bytes += file_bytes;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_taken != bytes_total) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d bytes in %0d files; checked %0d results", bytes_total, files_sent,
             results_taken);
    $display("  (%0d headers, %0d pixels, %0d errors)", headers_seen, pixels_seen,
             errors_seen);
    if (mismatches == 0) begin
      $display("netpbm_stream_decoder_top_test: PASS");
    end else begin
      $display("netpbm_stream_decoder_top_test: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timed out with %0d of %0d bytes taken, %0d results outstanding", bytes_taken,
             bytes_total, results_due.size());
    $display("netpbm_stream_decoder_top_test: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
src/npbm_pkg.sv
src/npbm_parser.sv
src/npbm_out_reg.sv
src/netpbm_stream_decoder_top.sv
verif/netpbm_stream_decoder_top_test.sv
